// File: sv/scene_register_table_macros.svh
// assertion macros shared by the scene register table rtl
`ifndef SCENE_REGISTER_TABLE_MACROS_SVH
`define SCENE_REGISTER_TABLE_MACROS_SVH

// same-cycle implication, clocked on aclk and disabled in reset
`define SRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scene register table check failed");

// next-cycle implication, clocked on aclk and disabled in reset
`define SRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scene register table check failed");

`endif

// File: sv/srt_pkg.sv
// shared types, codes and widths of the scene register table
`timescale 1ns / 1ps

package srt_pkg;

    // default sizing
    localparam int DEF_ELEMENTS = 4;
    localparam int DEF_SLOTS    = 16;

    // field widths
    localparam int CMD_W    = 3;
    localparam int ELEM_W   = 2;
    localparam int ID_W     = 16;
    localparam int LVL_W    = 8;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = ID_W + LVL_W;

    // stream widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    // command codes
    localparam logic [CMD_W-1:0] CMD_STORE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RECALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

    // one result transfer
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     active_scene;
        logic [LVL_W-1:0]    apply_level;
        logic                apply_valid;
        logic [ID_W-1:0]     listed_id;
        logic                id_valid;
        logic                last;
    } srt_item_t;

endpackage

// File: sv/srt_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/srt_out.sv
// result output register for the scene register table
`timescale 1ns / 1ps

module srt_out (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  srt_pkg::srt_item_t             item,
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, active_scene, apply_level, apply_valid, listed_id, zero pad
    output logic [srt_pkg::M_TDATA_W-1:0]  m_tdata,
    // id_valid
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast
);

    localparam int USED_W = srt_pkg::STATUS_W + 2 * srt_pkg::ID_W + srt_pkg::LVL_W + 1;
    localparam int PAD_W  = srt_pkg::M_TDATA_W - USED_W;

    logic               valid_reg;
    logic               valid_next;
    srt_pkg::srt_item_t item_reg;

    // register may take a new item when empty or when drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds until the next load
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
        end
    end

    // pack the result transfer
    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, item_reg.listed_id, item_reg.apply_valid,
                       item_reg.apply_level, item_reg.active_scene, item_reg.status};
    assign m_tuser  = item_reg.id_valid;
    assign m_tlast  = item_reg.last;

endmodule

// File: sv/scene_register_table.sv
// scene register table: per-element scene slots in one ram, swept one slot a cycle
// a command on a valid element runs the scan on the single ram read port, then an
// update state and a header state; with ack set, the id list then rereads the slots;
// clear all runs a clearing pass over every slot before the header; output stalls hold
// the header and the list; a new command is taken only once the previous one is done
// reset: a clearing pass over every slot runs before the first input transfer
`timescale 1ns / 1ps

module scene_register_table #(
    parameter int ELEMENTS = srt_pkg::DEF_ELEMENTS,
    parameter int SLOTS    = srt_pkg::DEF_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // command, element, scene_num, store_level, ack, zero pad
    input  logic [srt_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status, active_scene, apply_level, apply_valid, listed_id, zero pad
    output logic [srt_pkg::M_TDATA_W-1:0] m_tdata,
    // id_valid
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast
);

`include "scene_register_table_macros.svh"

    localparam int DEPTH  = ELEMENTS * SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int EL_W   = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam int ID_W   = srt_pkg::ID_W;
    localparam int LVL_W  = srt_pkg::LVL_W;
    localparam int WORD_W = srt_pkg::WORD_W;

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_HEAD  = 3'd4;
    localparam logic [2:0] S_LIST  = 3'd5;

    // input fields
    logic [srt_pkg::CMD_W-1:0]  in_cmd;
    logic [srt_pkg::ELEM_W-1:0] in_element;
    logic [ID_W-1:0]            in_id;
    logic [LVL_W-1:0]           in_lvl;
    logic                       in_ack;
    logic                       in_bad;
    logic [EL_W-1:0]            in_el_idx;
    logic                       accept;

    assign in_cmd     = s_tdata[2:0];
    assign in_element = s_tdata[4:3];
    assign in_id      = s_tdata[20:5];
    assign in_lvl     = s_tdata[28:21];
    assign in_ack     = s_tdata[29];
    assign in_bad     = int'(in_element) >= ELEMENTS;
    assign in_el_idx  = EL_W'(in_element);

    // control registers
    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              clr_cmd_reg, clr_cmd_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic              match_found_reg, match_found_next;
    logic              empty_found_reg, empty_found_next;
    logic [CNT_W-1:0]  nz_cnt_reg, nz_cnt_next;
    logic [CNT_W-1:0]  list_cnt_reg, list_cnt_next;
    logic [CNT_W-1:0]  lrd_idx_reg, lrd_idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [ID_W-1:0]   cur_scene_reg [ELEMENTS];
    logic [ID_W-1:0]   cur_scene_next [ELEMENTS];

    // command and scan payload registers
    logic [srt_pkg::CMD_W-1:0]    cmd_reg, cmd_next;
    logic [EL_W-1:0]              el_reg, el_next;
    logic [ID_W-1:0]              id_reg, id_next;
    logic [LVL_W-1:0]             lvl_reg, lvl_next;
    logic                         ack_reg, ack_next;
    logic [ADDR_W-1:0]            base_reg, base_next;
    logic [IDX_W-1:0]             match_idx_reg, match_idx_next;
    logic [LVL_W-1:0]             match_lvl_reg, match_lvl_next;
    logic [IDX_W-1:0]             empty_idx_reg, empty_idx_next;
    logic [srt_pkg::STATUS_W-1:0] hdr_status_reg, hdr_status_next;
    logic [ID_W-1:0]              hdr_cur_reg, hdr_cur_next;
    logic [LVL_W-1:0]             hdr_lvl_reg, hdr_lvl_next;
    logic                         hdr_av_reg, hdr_av_next;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic [ID_W-1:0]   rd_id;

    // output stage
    logic               out_load;
    logic               out_free;
    srt_pkg::srt_item_t out_item;

    // scan and list strobes
    logic             scan_issue;
    logic             scan_proc;
    logic [IDX_W-1:0] scan_idx;
    logic             list_emit;
    logic             list_last;
    logic             list_consume;
    logic             list_issue;
    logic             hdr_last;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rd_id    = ram_rdata[ID_W-1:0];

    // scan: issue slot reads, check the slot read in the cycle before
    assign scan_issue = (state_reg == S_SCAN) && (scan_cnt_reg < CNT_W'(SLOTS));
    assign scan_proc  = (state_reg == S_SCAN) && (scan_cnt_reg != '0);
    assign scan_idx   = IDX_W'(scan_cnt_reg - CNT_W'(1));

    // list: a pending slot word is dropped if empty or sent when the output is free
    assign list_emit    = (state_reg == S_LIST) && pend_reg && (rd_id != '0) && out_free;
    assign list_last    = list_emit && (emit_cnt_reg + CNT_W'(1) == list_cnt_reg);
    assign list_consume = (state_reg == S_LIST) && pend_reg && ((rd_id == '0) || out_free);
    assign list_issue   = (state_reg == S_LIST) && (!pend_reg || list_consume) && !list_last
                          && (lrd_idx_reg < CNT_W'(SLOTS));

    assign hdr_last = !ack_reg || (list_cnt_reg == '0);

    assign ram_re    = scan_issue || list_issue;
    assign ram_raddr = base_reg + (scan_issue ? ADDR_W'(scan_cnt_reg) : ADDR_W'(lrd_idx_reg));

    // sequencer
    always_comb begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        clr_cmd_next     = clr_cmd_reg;
        scan_cnt_next    = scan_cnt_reg;
        match_found_next = match_found_reg;
        empty_found_next = empty_found_reg;
        nz_cnt_next      = nz_cnt_reg;
        list_cnt_next    = list_cnt_reg;
        lrd_idx_next     = lrd_idx_reg;
        pend_next        = pend_reg;
        emit_cnt_next    = emit_cnt_reg;
        cur_scene_next   = cur_scene_reg;
        cmd_next         = cmd_reg;
        el_next          = el_reg;
        id_next          = id_reg;
        lvl_next         = lvl_reg;
        ack_next         = ack_reg;
        base_next        = base_reg;
        match_idx_next   = match_idx_reg;
        match_lvl_next   = match_lvl_reg;
        empty_idx_next   = empty_idx_reg;
        hdr_status_next  = hdr_status_reg;
        hdr_cur_next     = hdr_cur_reg;
        hdr_lvl_next     = hdr_lvl_reg;
        hdr_av_next      = hdr_av_reg;
        ram_we           = 1'b0;
        ram_waddr        = clr_addr_reg;
        ram_wdata        = '0;
        out_load         = 1'b0;
        out_item         = '0;

        case (state_reg)
            // clearing pass over every slot
            S_CLEAR: begin
                ram_we = 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = clr_cmd_reg ? S_HEAD : S_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            // take a command
            S_IDLE: begin
                if (accept) begin
                    cmd_next         = in_cmd;
                    el_next          = in_el_idx;
                    id_next          = in_id;
                    lvl_next         = in_lvl;
                    ack_next         = in_ack;
                    base_next        = ADDR_W'(in_el_idx) * ADDR_W'(SLOTS);
                    scan_cnt_next    = '0;
                    match_found_next = 1'b0;
                    empty_found_next = 1'b0;
                    nz_cnt_next      = '0;
                    hdr_status_next  = srt_pkg::ST_OK;
                    hdr_cur_next     = '0;
                    hdr_lvl_next     = '0;
                    hdr_av_next      = 1'b0;
                    list_cnt_next    = '0;
                    if (in_bad) begin
                        hdr_status_next = srt_pkg::ST_NOTFOUND;
                        state_next      = S_HEAD;
                    end else if (in_cmd == srt_pkg::CMD_CLEAR) begin
                        for (int e = 0; e < ELEMENTS; e++) begin
                            cur_scene_next[e] = '0;
                        end
                        clr_addr_next = '0;
                        clr_cmd_next  = 1'b1;
                        state_next    = S_CLEAR;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end

            // sweep the element's slots
            S_SCAN: begin
                if (scan_proc) begin
                    if ((rd_id == id_reg) && !match_found_reg) begin
                        match_found_next = 1'b1;
                        match_idx_next   = scan_idx;
                        match_lvl_next   = ram_rdata[WORD_W-1:ID_W];
                    end
                    if ((rd_id == '0) && !empty_found_reg) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = scan_idx;
                    end
                    if (rd_id != '0) begin
                        nz_cnt_next = nz_cnt_reg + CNT_W'(1);
                    end
                end
                if (scan_cnt_reg == CNT_W'(SLOTS)) begin
                    state_next = S_WRITE;
                end else begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
            end

            // apply the command to the slot and the current scene
            S_WRITE: begin
                hdr_cur_next  = cur_scene_reg[el_reg];
                list_cnt_next = nz_cnt_reg;
                case (cmd_reg)
                    srt_pkg::CMD_STORE: begin
                        if (id_reg == '0) begin
                            hdr_status_next = srt_pkg::ST_INVALID;
                        end else if (match_found_reg || empty_found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = base_reg + ADDR_W'(match_found_reg ? match_idx_reg
                                                                           : empty_idx_reg);
                            ram_wdata = {lvl_reg, id_reg};
                            hdr_cur_next = id_reg;
                            if (!match_found_reg) begin
                                list_cnt_next = nz_cnt_reg + CNT_W'(1);
                            end
                        end else begin
                            hdr_status_next = srt_pkg::ST_FULL;
                        end
                    end
                    srt_pkg::CMD_DELETE: begin
                        if (match_found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = base_reg + ADDR_W'(match_idx_reg);
                            ram_wdata = '0;
                            if (cur_scene_reg[el_reg] == id_reg) begin
                                hdr_cur_next = '0;
                            end
                            if (id_reg != '0) begin
                                list_cnt_next = nz_cnt_reg - CNT_W'(1);
                            end
                        end
                    end
                    srt_pkg::CMD_RECALL: begin
                        if ((id_reg != '0) && match_found_reg) begin
                            hdr_lvl_next = match_lvl_reg;
                            hdr_av_next  = 1'b1;
                            hdr_cur_next = id_reg;
                        end else begin
                            hdr_status_next = srt_pkg::ST_NOTFOUND;
                        end
                    end
                    default: begin
                        // query and unused codes change nothing
                    end
                endcase
                cur_scene_next[el_reg] = hdr_cur_next;
                state_next = S_HEAD;
            end

            // header transfer
            S_HEAD: begin
                if (out_free) begin
                    out_load              = 1'b1;
                    out_item.status       = hdr_status_reg;
                    out_item.active_scene = hdr_cur_reg;
                    out_item.apply_level  = hdr_lvl_reg;
                    out_item.apply_valid  = hdr_av_reg;
                    out_item.last         = hdr_last;
                    clr_cmd_next          = 1'b0;
                    lrd_idx_next          = '0;
                    pend_next             = 1'b0;
                    emit_cnt_next         = '0;
                    state_next            = hdr_last ? S_IDLE : S_LIST;
                end
            end

            // stored id list, one slot read a cycle unless a pending id waits for the output
            S_LIST: begin
                if (list_emit) begin
                    out_load           = 1'b1;
                    out_item.listed_id = rd_id;
                    out_item.id_valid  = 1'b1;
                    out_item.last      = list_last;
                    emit_cnt_next      = emit_cnt_reg + CNT_W'(1);
                end
                if (list_issue) begin
                    lrd_idx_next = lrd_idx_reg + CNT_W'(1);
                    pend_next    = 1'b1;
                end else if (list_consume) begin
                    pend_next = 1'b0;
                end
                if (list_last) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            clr_cmd_reg     <= 1'b0;
            scan_cnt_reg    <= '0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            nz_cnt_reg      <= '0;
            list_cnt_reg    <= '0;
            lrd_idx_reg     <= '0;
            pend_reg        <= 1'b0;
            emit_cnt_reg    <= '0;
            for (int e = 0; e < ELEMENTS; e++) begin
                cur_scene_reg[e] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            clr_cmd_reg     <= clr_cmd_next;
            scan_cnt_reg    <= scan_cnt_next;
            match_found_reg <= match_found_next;
            empty_found_reg <= empty_found_next;
            nz_cnt_reg      <= nz_cnt_next;
            list_cnt_reg    <= list_cnt_next;
            lrd_idx_reg     <= lrd_idx_next;
            pend_reg        <= pend_next;
            emit_cnt_reg    <= emit_cnt_next;
            cur_scene_reg   <= cur_scene_next;
        end
    end

    // command and scan payload
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        el_reg         <= el_next;
        id_reg         <= id_next;
        lvl_reg        <= lvl_next;
        ack_reg        <= ack_next;
        base_reg       <= base_next;
        match_idx_reg  <= match_idx_next;
        match_lvl_reg  <= match_lvl_next;
        empty_idx_reg  <= empty_idx_next;
        hdr_status_reg <= hdr_status_next;
        hdr_cur_reg    <= hdr_cur_next;
        hdr_lvl_reg    <= hdr_lvl_next;
        hdr_av_reg     <= hdr_av_next;
    end

    // slot memory: level in the upper bits, scene id in the lower bits
    srt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // result register
    srt_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (out_load),
        .item    (out_item),
        .free    (out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    // checks
    `SRT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `SRT_ASSERT_SAME(a_list_item_nonzero, out_load && (state_reg == S_LIST), out_item.id_valid && (out_item.listed_id != '0))
    `SRT_ASSERT_SAME(a_emit_bound, state_reg == S_LIST, emit_cnt_reg < list_cnt_reg)
    `SRT_ASSERT_SAME(a_no_read_on_write, ram_we, !ram_re)

endmodule
